// ===== hw/rtl/kps_pkg.sv =====
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and code helper for the keypad scanner.
// ----------------------------------------------------------------------------
package kps_pkg;

  localparam int unsigned ROW_N   = 4;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned LINE_W  = 2;
  localparam int unsigned CODE_W  = 7;

  // operation codes of an input item
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  // push request from the scan logic to the key store
  typedef struct packed {
    logic [ROW_N-1:0]  row_mask;
    logic [LINE_W-1:0] line;
  } push_req_t;

  // upper three bits are row plus one, low nibble is the line
  function automatic logic [CODE_W-1:0] key_code_f(logic [1:0] row, logic [LINE_W-1:0] line);
    logic [2:0] row_p1;
    row_p1 = {1'b0, row} + 3'd1;
    return {row_p1, 2'b00, line};
  endfunction

endpackage

// ===== hw/rtl/matrix_keypad_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_unit: 4x4 keypad scanner with a key code store
// Path: an accepted item is held in the input register, then moves to the result register.
// Throughput: one item per cycle while the output is not stalled; stage, column and store update together.
// Reset: stage, column and key count cleared; stored codes are not reset.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_unit #(
  parameter int unsigned STACK_DEPTH = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [kps_pkg::ROW_N-1:0]   in_row_levels,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kps_pkg::COL_W-1:0]   out_column_drive,
  output logic                        out_key_valid,
  output logic [kps_pkg::CODE_W-1:0]  out_key_code
);
  import kps_pkg::*;

  logic               in_v_r;
  op_t                op_r;
  logic [ROW_N-1:0]   rows_r;
  logic               out_v_r;
  logic [COL_W-1:0]   column_out_r;
  logic               key_valid_r;
  logic [CODE_W-1:0]  key_code_r;
  logic               advance;
  logic               fire;
  logic [COL_W-1:0]   column_nxt;
  push_req_t          push_req;
  logic               pop_valid;
  logic [CODE_W-1:0]  pop_code;

  // handshake: the item moves on when the result register is free
  assign advance  = !out_v_r || !out_stall;
  assign fire     = in_v_r && advance;
  assign in_stall = in_v_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r   <= op_t'(in_operation);
      rows_r <= in_row_levels;
    end
  end

  kps_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (fire && (op_r == OP_TICK)),
    .rows       (rows_r),
    .column_nxt (column_nxt),
    .push_req   (push_req)
  );

  kps_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_req  (push_req),
    .pop       (fire && (op_r == OP_FETCH)),
    .pop_valid (pop_valid),
    .pop_code  (pop_code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      column_out_r <= column_nxt;
      key_valid_r  <= pop_valid;
      key_code_r   <= pop_code;
    end
  end

  assign out_valid        = out_v_r;
  assign out_column_drive = column_out_r;
  assign out_key_valid    = key_valid_r;
  assign out_key_code     = key_code_r;

`ifndef SYNTHESIS
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !key_valid_r |-> (key_code_r == '0))
    else $error("key code set without a valid key");
`endif

endmodule

// ===== hw/rtl/kps_scan.sv =====
// ----------------------------------------------------------------------------
// kps_scan
// Stage counter and column register; builds push requests on odd stages.
// ----------------------------------------------------------------------------
module kps_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick_en,
  input  logic [kps_pkg::ROW_N-1:0]   rows,
  output logic [kps_pkg::COL_W-1:0]   column_nxt,
  output kps_pkg::push_req_t          push_req
);
  import kps_pkg::*;

  logic [STAGE_W-1:0] stage_r;
  logic [STAGE_W-1:0] stage_nxt;
  logic [COL_W-1:0]   column_r;
  logic [LINE_W-1:0]  line;

  // advance the stage and drive or sample
  always_comb begin
    stage_nxt         = stage_r;
    column_nxt        = column_r;
    push_req.row_mask = '0;
    line              = stage_r[2:1] + LINE_W'(stage_r[0]);
    push_req.line     = line;
    if (tick_en) begin
      stage_nxt     = stage_r + STAGE_W'(1);
      line          = stage_nxt[2:1];
      push_req.line = line;
      if (!stage_nxt[0]) begin
        column_nxt = COL_W'(1) << line;
      end else begin
        push_req.row_mask = rows;
      end
    end
  end

  // stage and column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= '0;
      column_r <= '0;
    end else begin
      stage_r  <= stage_nxt;
      column_r <= column_nxt;
    end
  end

`ifndef SYNTHESIS
  a_column_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(column_r)) else $error("column register drives more than one column");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_en |=> $stable(stage_r) && $stable(column_r))
    else $error("scan state changed without a tick");
`endif

endmodule

// ===== hw/rtl/kps_stack.sv =====
// ----------------------------------------------------------------------------
// kps_stack
// Last-in-first-out key store: up to four pushes or one pop per cycle.
// ----------------------------------------------------------------------------
module kps_stack #(
  parameter int unsigned STACK_DEPTH = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kps_pkg::push_req_t          push_req,
  input  logic                        pop,
  output logic                        pop_valid,
  output logic [kps_pkg::CODE_W-1:0]  pop_code
);
  import kps_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CODE_W-1:0] stack_r   [STACK_DEPTH];
  logic [CODE_W-1:0] stack_nxt [STACK_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  top_idx;

  // pop the newest code, or push the high rows lowest first
  always_comb begin
    stack_nxt = stack_r;
    count_nxt = count_r;
    pop_valid = 1'b0;
    pop_code  = '0;
    top_idx   = count_r - CNT_W'(1);
    if (pop && (count_r != '0)) begin
      count_nxt = top_idx;
      pop_valid = 1'b1;
      pop_code  = stack_r[top_idx[IDX_W-1:0]];
    end
    for (int i = 0; i < ROW_N; i++) begin
      if (push_req.row_mask[i] && (count_nxt < CNT_W'(STACK_DEPTH))) begin
        stack_nxt[count_nxt[IDX_W-1:0]] = key_code_f(2'(i), push_req.line);
        count_nxt = count_nxt + CNT_W'(1);
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // stored codes, no reset
  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH)) else $error("key count beyond store depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid |-> (count_r != '0) && (push_req.row_mask == '0))
    else $error("pop from empty store or pop mixed with push");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keypad scanner testbench
// Drives scan ticks and key fetches through the valid/stall input channel,
// predicts every result with a cycle-free model of the stage counter, column
// register and key stack, and checks each result item field by field while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import kps_pkg::*;

  localparam int unsigned KEY_DEPTH      = 6;
  localparam int unsigned ROW_STEP       = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // one predicted result item
  typedef struct {
    logic [COL_W-1:0]  column;
    logic              key_valid;
    logic [CODE_W-1:0] code;
  } scan_result_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_operation  = OP_TICK;
  logic [ROW_N-1:0]    in_row_levels = '0;
  logic                out_stall     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [COL_W-1:0]    out_column_drive;
  logic                out_key_valid;
  logic [CODE_W-1:0]   out_key_code;

  // predicted keypad state
  logic [STAGE_W-1:0]  stage_q  = '0;
  logic [COL_W-1:0]    column_q = '0;
  logic [CODE_W-1:0]   key_store_q [KEY_DEPTH];
  int unsigned         key_depth_q = 0;

  scan_result_t        results_due [$];
  int unsigned         error_count = 0;
  int unsigned         quiet_cycles = 0;

  matrix_keypad_scanner_unit #(
    .STACK_DEPTH(KEY_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_row_levels    (in_row_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_drive (out_column_drive),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code)
  );

  always #2 clk = ~clk;

  // advance the predicted keypad by one item and return its result
  function automatic scan_result_t predict_scan(op_t op, logic [ROW_N-1:0] rows);
    scan_result_t      res;
    logic [LINE_W-1:0] line;
    res.key_valid = 1'b0;
    res.code      = '0;
    if (op == OP_TICK) begin
      stage_q = stage_q + 1'b1;
      line    = stage_q[2:1];
      if (!stage_q[0]) begin
        column_q = 4'b0001 << line;
      end else begin
        // row 0 first, so the highest row ends up on top
        for (int i = 0; i < ROW_N; i++) begin
          if (rows[i] && key_depth_q < KEY_DEPTH) begin
            key_store_q[key_depth_q] = CODE_W'((i + 1) * ROW_STEP) | CODE_W'(line);
            key_depth_q++;
          end
        end
      end
    end else if (key_depth_q != 0) begin
      key_depth_q--;
      res.code      = key_store_q[key_depth_q];
      res.key_valid = 1'b1;
    end
    res.column = column_q;
    return res;
  endfunction

  // present one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(op_t op, logic [ROW_N-1:0] rows);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_row_levels <= rows;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(predict_scan(op, rows));
  endtask

  // drop valid for a number of cycles
  task automatic hold_off(int unsigned cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ROW_N-1:0] random_rows();
    logic [ROW_N-1:0] rows;
    case ($urandom_range(0, 3))
      0:       rows = '0;
      1:       rows = 4'b0001 << $urandom_range(0, 3);
      default: rows = ROW_N'($urandom_range(0, 15));
    endcase
    return rows;
  endfunction

  // fetches from a store that is still empty, row levels ignored
  task automatic test_empty_store();
    send_item(OP_FETCH, 4'h0);
    send_item(OP_FETCH, 4'hF);
    hold_off(3);
  endtask

  // one full turn of the stage counter, all rows on a line and single rows
  task automatic test_scan_cycle();
    send_item(OP_TICK, 4'hF);
    send_item(OP_TICK, 4'hF);
    send_item(OP_TICK, 4'h1);
    send_item(OP_TICK, 4'h0);
    hold_off(1);
    send_item(OP_TICK, 4'h8);
    send_item(OP_TICK, 4'h0);
    send_item(OP_TICK, 4'h0);
    send_item(OP_TICK, 4'h0);
    hold_off(2);
  endtask

  // pushes into a full store are dropped, then the store is emptied and overrun
  task automatic test_store_overflow();
    send_item(OP_TICK, 4'hF);
    for (int i = 0; i < KEY_DEPTH + 1; i++) begin
      send_item(OP_FETCH, (i % 2) ? 4'hF : 4'h0);
    end
    send_item(OP_TICK, 4'h0);
    send_item(OP_TICK, 4'h4);
    send_item(OP_FETCH, 4'h0);
    hold_off(2);
  endtask

  // sender stops until every expected result has come back
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    send_item(OP_FETCH, 4'h0);
    hold_off(1);
  endtask

  // random bursts with phases that favor filling or emptying the store
  task automatic test_random_traffic(int unsigned item_total);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned tick_pct;
    bit          no_gaps;
    sent = 0;
    while (sent < item_total) begin
      case ($urandom_range(0, 2))
        0:       tick_pct = 25;
        1:       tick_pct = 50;
        default: tick_pct = 85;
      endcase
      no_gaps   = ($urandom_range(0, 9) == 0);
      burst_len = no_gaps ? $urandom_range(40, 120) : $urandom_range(1, 24);
      for (int k = 0; k < burst_len && sent < item_total; k++) begin
        if ($urandom_range(1, 100) <= tick_pct) send_item(OP_TICK, random_rows());
        else send_item(OP_FETCH, ROW_N'($urandom_range(0, 15)));
        sent++;
      end
      if (!no_gaps) hold_off($urandom_range(1, 10));
    end
  endtask

  // receiver stall pattern: runs of free flow, light, heavy and periodic stalling
  always @(posedge clk) begin : stall_pattern
    int unsigned mode;
    int unsigned mode_left;
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 200);
    end
    mode_left--;
    case (mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (mode_left[2:0] < 3);
    endcase
  end

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin : check_results
    scan_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result item with no prediction pending");
        error_count++;
      end else begin
        due = results_due.pop_front();
        if (out_column_drive !== due.column) begin
          $error("column_drive: expected %0h, got %0h", due.column, out_column_drive);
          error_count++;
        end
        if (out_key_valid !== due.key_valid) begin
          $error("key_valid: expected %0b, got %0b", due.key_valid, out_key_valid);
          error_count++;
        end
        if (out_key_code !== due.code) begin
          $error("key_code: expected %0h, got %0h", due.code, out_key_code);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_scan_cycle();
    test_store_overflow();
    test_random_traffic(700);
    test_drain_pause();
    test_random_traffic(750);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d predicted results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
